// ===== hdl/accm_pkg.sv =====
`default_nettype none
package accm_pkg;

    localparam int MEM_WORDS = 100;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int WORD_W    = 16;

    // request opcodes
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_EXEC    = 2'd2;

    // instruction groups (hundreds digit)
    localparam logic [3:0] GRP_ADD   = 4'd1;
    localparam logic [3:0] GRP_SUB   = 4'd2;
    localparam logic [3:0] GRP_STORE = 4'd3;
    localparam logic [3:0] GRP_LOAD  = 4'd5;
    localparam logic [3:0] GRP_BRA   = 4'd6;
    localparam logic [3:0] GRP_BRZ   = 4'd7;
    localparam logic [3:0] GRP_BRP   = 4'd8;
    localparam logic [3:0] GRP_IO    = 4'd9;

    localparam logic [ADDR_W-1:0] IO_INPUT  = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] IO_OUTPUT = ADDR_W'(2);

    localparam logic [WORD_W-1:0] WORD_LIMIT = WORD_W'(1000);

    typedef struct packed {
        logic [1:0]              opcode;
        logic [ADDR_W-1:0]       address;
        logic signed [WORD_W-1:0] word;
        logic signed [WORD_W-1:0] in_value;
    } t_in_req;

    typedef struct packed {
        logic                     status;
        logic                     out_valid;
        logic signed [WORD_W-1:0] out_value;
        logic [ADDR_W-1:0]        next_pc;
        logic signed [WORD_W-1:0] acc_now;
    } t_out_req;

    typedef struct packed {
        logic [3:0]        grp;
        logic [ADDR_W-1:0] opnd;
    } t_dec;

    // Split a word in 0..999 into hundreds digit and operand.
    // x*41 >> 12 equals x/100 over that range.
    function automatic t_dec dec_word(input logic [9:0] w);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [9:0]  rem;
        t_dec        d;
        prod   = 16'(w) * 16'd41;
        q      = prod[15:12];
        rem    = w - 10'(q) * 10'd100;
        d.grp  = q;
        d.opnd = rem[ADDR_W-1:0];
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/accm_ram.sv =====
`default_nettype none
module accm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/accm_obuf.sv =====
`default_nettype none
module accm_obuf import accm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_out_req i_push_req,
    output logic          o_ready,
    output logic          o_out_valid,
    output t_out_req      o_out_req,
    input  wire logic     i_out_stall
);

    logic     r_vld;
    t_out_req r_req;

    assign o_ready     = !r_vld || !i_out_stall;
    assign o_out_valid = r_vld;
    assign o_out_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push && o_ready) begin
            r_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            r_req <= i_push_req;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/accm_seq.sv =====
`default_nettype none
module accm_seq import accm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire t_in_req           i_in_req,
    output logic                   o_in_stall,
    output logic                   o_rd_en,
    output logic [ADDR_W-1:0]      o_rd_addr,
    input  wire logic [WORD_W-1:0] i_rd_data,
    output logic                   o_wr_en,
    output logic [ADDR_W-1:0]      o_wr_addr,
    output logic [WORD_W-1:0]      o_wr_data,
    output logic                   o_push,
    output t_out_req               o_push_req,
    input  wire logic              i_push_ready
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_OPER  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [ADDR_W-1:0]     r_pc, n_pc;
    logic [WORD_W-1:0]     r_acc, n_acc;
    logic                  r_halt, n_halt;
    logic [MEM_WORDS-1:0]  r_vld, n_vld;
    logic                  r_rd_vld;
    logic [WORD_W-1:0]     r_in_value, n_in_value;
    logic [3:0]            r_kind, n_kind;
    t_out_req              r_hold, n_hold;

    logic                  fin;
    logic                  emit;
    logic [WORD_W-1:0]     mem_q;
    t_dec                  dec;
    t_out_req              res;

    assign mem_q = r_rd_vld ? i_rd_data : '0;
    assign dec   = dec_word(mem_q[9:0]);

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_acc      = r_acc;
        n_halt     = r_halt;
        n_vld      = r_vld;
        n_in_value = r_in_value;
        n_kind     = r_kind;
        n_hold     = r_hold;
        fin        = 1'b0;
        emit       = 1'b0;
        o_in_stall = 1'b1;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_pc;
        o_wr_en    = 1'b0;
        o_wr_addr  = i_in_req.address;
        o_wr_data  = i_in_req.word;

        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_in_value = i_in_req.in_value;
                    case (i_in_req.opcode)
                        OP_WRITE: begin
                            if (i_in_req.address < ADDR_W'(MEM_WORDS)) begin
                                o_wr_en                  = 1'b1;
                                n_vld[i_in_req.address] = 1'b1;
                            end
                            fin = 1'b1;
                        end
                        OP_RESTART: begin
                            n_pc   = '0;
                            n_acc  = '0;
                            n_halt = 1'b0;
                            fin    = 1'b1;
                        end
                        OP_EXEC: begin
                            if (r_halt) begin
                                fin = 1'b1;
                            end else begin
                                o_rd_en = 1'b1;
                                n_state = S_FETCH;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_pc = (r_pc == ADDR_W'(MEM_WORDS - 1)) ? '0 : r_pc + 1'b1;
                fin  = 1'b1;
                if (mem_q == '0) begin
                    n_halt = 1'b1;
                end else if (!mem_q[WORD_W-1] && mem_q < WORD_LIMIT) begin
                    case (dec.grp)
                        GRP_ADD, GRP_SUB, GRP_LOAD: begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = dec.opnd;
                            n_kind    = dec.grp;
                            n_state   = S_OPER;
                            fin       = 1'b0;
                        end
                        GRP_STORE: begin
                            o_wr_en          = 1'b1;
                            o_wr_addr        = dec.opnd;
                            o_wr_data        = r_acc;
                            n_vld[dec.opnd] = 1'b1;
                        end
                        GRP_BRA: n_pc = dec.opnd;
                        GRP_BRZ: begin
                            if (r_acc == '0) begin
                                n_pc = dec.opnd;
                            end
                        end
                        GRP_BRP: begin
                            if (!r_acc[WORD_W-1]) begin
                                n_pc = dec.opnd;
                            end
                        end
                        GRP_IO: begin
                            if (dec.opnd == IO_INPUT) begin
                                n_acc = r_in_value;
                            end else if (dec.opnd == IO_OUTPUT) begin
                                emit = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_OPER: begin
                fin = 1'b1;
                case (r_kind)
                    GRP_ADD: n_acc = r_acc + mem_q;
                    GRP_SUB: n_acc = r_acc - mem_q;
                    default: n_acc = mem_q;
                endcase
            end
            S_DONE: begin
                if (i_push_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        res.status    = n_halt;
        res.out_valid = emit;
        res.out_value = emit ? r_acc : '0;
        res.next_pc   = n_pc;
        res.acc_now   = n_acc;

        o_push     = fin || (r_state == S_DONE);
        o_push_req = (r_state == S_DONE) ? r_hold : res;

        // hold the result until the output register frees up
        if (fin) begin
            n_state = i_push_ready ? S_IDLE : S_DONE;
            n_hold  = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_acc   <= '0;
            r_halt  <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_acc   <= n_acc;
            r_halt  <= n_halt;
            r_vld   <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_value <= n_in_value;
        r_kind     <= n_kind;
        r_hold     <= n_hold;
        if (o_rd_en) begin
            r_rd_vld <= r_vld[o_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/accumulator_machine_core.sv =====
`default_nettype none
// Decimal accumulator machine with a 100-word data/program memory.
// Input channel (i_in_valid / i_in_req / o_in_stall) carries one request:
// write a memory word, restart (pc, accumulator and halt flag cleared,
// memory kept) or execute one instruction. Every request gives exactly one
// result on the output channel (o_out_valid / o_out_req / i_out_stall).
// Write, restart and a step while halted are answered straight from idle;
// a step fetches its instruction, and add, subtract and load then go on to
// read their operand from the single memory read port after the
// instruction fetch. A new request is taken as soon as the sequencer is
// back in idle, so a step must finish before the next request is taken.
// The output register lets a request be taken while the previous result
// waits; if it is still stalled when the next result is ready, the
// sequencer holds that result and stalls the input.
// Reset (synchronous, active low) clears pc, accumulator, halt flag and the
// per-word valid bits, so all memory reads back as zero until written.
module accumulator_machine_core import accm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_req  i_in_req,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output t_out_req      o_out_req,
    input  wire logic     i_out_stall
);

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              push;
    t_out_req          push_req;
    logic              push_ready;

    accm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    accm_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_req     (i_in_req),
        .o_in_stall   (o_in_stall),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_push       (push),
        .o_push_req   (push_req),
        .i_push_ready (push_ready)
    );

    accm_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_req  (push_req),
        .o_ready     (push_ready),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall)
    );

endmodule
`default_nettype wire

// ===== test/accumulator_machine_core_test.sv =====
`default_nettype none
module accumulator_machine_core_test import accm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         IDLE_LIMIT  = 3000;
    localparam int         DRAIN_TICKS = 8;

    logic     i_clk;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_req  i_in_req    = '0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_req o_out_req;
    logic     i_out_stall = 1'b0;

    // shadow of the machine state
    logic [WORD_W-1:0] shadow_mem [MEM_WORDS];
    logic [ADDR_W-1:0] shadow_pc;
    logic [WORD_W-1:0] shadow_acc;
    logic              shadow_halt;

    t_out_req    report_q [$];
    int unsigned fail_count  = 0;
    int          items_sent  = 0;
    int          in_quiet    = 0;
    int          out_quiet   = 0;
    int          stall_left  = 0;
    int          idle_cycles = 0;

    accumulator_machine_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly short, now and then long, with stretches of none at all.
    function automatic int idle_len(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_out_req machine_step(input t_in_req req);
        t_out_req          rep;
        int                w;
        int                fetch;
        logic [3:0]        grp;
        logic [ADDR_W-1:0] opnd;
        rep = '0;
        case (req.opcode)
            OP_WRITE: begin
                if (req.address < MEM_WORDS) shadow_mem[req.address] = req.word;
            end
            OP_RESTART: begin
                shadow_pc   = '0;
                shadow_acc  = '0;
                shadow_halt = 1'b0;
            end
            OP_EXEC: begin
                if (!shadow_halt) begin
                    fetch     = int'(shadow_pc);
                    w         = int'($signed(shadow_mem[fetch]));
                    shadow_pc = (fetch == MEM_WORDS - 1) ? '0 : ADDR_W'(fetch + 1);
                    if (w == 0) begin
                        shadow_halt = 1'b1;
                    end else if (w > 0 && w < 1000) begin
                        grp  = 4'(w / 100);
                        opnd = ADDR_W'(w % 100);
                        case (grp)
                            GRP_ADD:   shadow_acc = shadow_acc + shadow_mem[opnd];
                            GRP_SUB:   shadow_acc = shadow_acc - shadow_mem[opnd];
                            GRP_STORE: shadow_mem[opnd] = shadow_acc;
                            GRP_LOAD:  shadow_acc = shadow_mem[opnd];
                            GRP_BRA:   shadow_pc = opnd;
                            GRP_BRZ: begin
                                if (shadow_acc == '0) shadow_pc = opnd;
                            end
                            GRP_BRP: begin
                                if (!shadow_acc[WORD_W-1]) shadow_pc = opnd;
                            end
                            GRP_IO: begin
                                if (opnd == IO_INPUT) begin
                                    shadow_acc = req.in_value;
                                end else if (opnd == IO_OUTPUT) begin
                                    rep.out_valid = 1'b1;
                                    rep.out_value = shadow_acc;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase
        rep.status  = shadow_halt;
        rep.next_pc = shadow_pc;
        rep.acc_now = shadow_acc;
        return rep;
    endfunction

    task automatic issue_request(input t_in_req req);
        int gap;
        gap = idle_len(in_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (o_in_stall);
        report_q.push_back(machine_step(req));
        items_sent++;
    endtask

    task automatic write_word(input logic [ADDR_W-1:0] addr, input int val);
        t_in_req r;
        r.opcode   = OP_WRITE;
        r.address  = addr;
        r.word     = WORD_W'(val);
        r.in_value = WORD_W'($urandom);
        issue_request(r);
    endtask

    task automatic exec_step(input int in_val);
        t_in_req r;
        r.opcode   = OP_EXEC;
        r.address  = ADDR_W'($urandom);
        r.word     = WORD_W'($urandom);
        r.in_value = WORD_W'(in_val);
        issue_request(r);
    endtask

    task automatic restart_machine();
        t_in_req r;
        r.opcode   = OP_RESTART;
        r.address  = ADDR_W'($urandom);
        r.word     = WORD_W'($urandom);
        r.in_value = WORD_W'($urandom);
        issue_request(r);
    endtask

    task automatic send_unused();
        t_in_req r;
        r.opcode   = OP_UNUSED;
        r.address  = ADDR_W'($urandom);
        r.word     = WORD_W'($urandom);
        r.in_value = WORD_W'($urandom);
        issue_request(r);
    endtask

    // Mostly real instructions; the rest halts, data and undefined words.
    function automatic int program_word(input int len);
        int r;
        int v;
        int tgt;
        int opnd;
        r    = $urandom_range(0, 99);
        tgt  = $urandom_range(0, len - 1);
        opnd = $urandom_range(0, MEM_WORDS - 1);
        if (r < 62) begin
            case ($urandom_range(0, 8))
                0: return int'(GRP_ADD) * 100 + opnd;
                1: return int'(GRP_SUB) * 100 + opnd;
                2: return int'(GRP_STORE) * 100 + opnd;
                3: return int'(GRP_LOAD) * 100 + opnd;
                4: return int'(GRP_BRA) * 100 + tgt;
                5: return int'(GRP_BRZ) * 100 + tgt;
                6: return int'(GRP_BRP) * 100 + tgt;
                7: return int'(GRP_IO) * 100 + int'(IO_INPUT);
                default: return int'(GRP_IO) * 100 + int'(IO_OUTPUT);
            endcase
        end
        if (r < 72) return 0;
        if (r < 80) return $urandom_range(1, 99);
        if (r < 86) return -int'($urandom_range(1, 32768));
        if (r < 91) return $urandom_range(1000, 32767);
        if (r < 95) return 400 + $urandom_range(0, 99);
        v = $urandom_range(0, 99);
        if (v == int'(IO_INPUT) || v == int'(IO_OUTPUT)) v = 0;
        return int'(GRP_IO) * 100 + v;
    endfunction

    task automatic test_edge_cases();
        exec_step(0);               // cleared memory: fetch 000 and halt
        exec_step(5);               // halted: nothing moves
        write_word(99, 902);        // write still lands while halted
        write_word(127, -32768);    // out of range, dropped
        send_unused();
        restart_machine();
    endtask

    task automatic test_instruction_set();
        write_word(0, 901);
        write_word(1, 199);
        write_word(2, 298);
        write_word(3, 397);
        write_word(4, 597);
        write_word(5, 799);
        write_word(6, 899);
        write_word(98, -32768);
        exec_step(32767);           // input
        exec_step(0);               // add wraps past the top
        exec_step(0);               // subtract the most negative word
        exec_step(0);               // store
        exec_step(0);               // load
        exec_step(0);               // branch if zero, not taken
        exec_step(0);               // branch if non-negative, taken to 99
        exec_step(0);               // output at 99, counter wraps to 0
        write_word(0, 55);
        exec_step(0);               // data word: fetch only
        write_word(1, -1);
        exec_step(0);               // negative word: fetch only
    endtask

    task automatic test_random_programs(input int n_items);
        int start;
        int len;
        int steps;
        int k;
        int r;
        start = items_sent;
        while (items_sent - start < n_items) begin
            restart_machine();
            len = $urandom_range(3, 16);
            for (k = 0; k < len; k++) write_word(ADDR_W'(k), program_word(len));
            repeat ($urandom_range(0, 4)) begin
                write_word(ADDR_W'($urandom_range(len, MEM_WORDS - 1)),
                           int'($urandom_range(0, 2000)) - 1000);
            end
            steps = $urandom_range(4, 3 * len);
            for (k = 0; k < steps; k++) begin
                r = $urandom_range(0, 99);
                if (r < 4) write_word(ADDR_W'($urandom), program_word(len));
                else if (r < 6) send_unused();
                else exec_step(int'($urandom));
            end
        end
    endtask

    task automatic test_random_noise(input int n_items);
        t_in_req r;
        repeat (n_items) begin
            r.opcode   = 2'($urandom_range(0, 3));
            r.address  = ADDR_W'($urandom);
            r.word     = WORD_W'($urandom);
            r.in_value = WORD_W'($urandom);
            issue_request(r);
        end
    endtask

    // Check each result and drive the output stall.
    always @(posedge i_clk) begin
        int       n;
        t_out_req exp;
        if (o_out_valid && !i_out_stall) begin
            if (report_q.size() == 0) begin
                $error("unexpected result: %p", o_out_req);
                fail_count++;
            end else begin
                exp = report_q.pop_front();
                if (o_out_req.status !== exp.status) begin
                    $error("status: expected %0d, got %0d", exp.status, o_out_req.status);
                    fail_count++;
                end
                if (o_out_req.out_valid !== exp.out_valid) begin
                    $error("out_valid: expected %0d, got %0d",
                           exp.out_valid, o_out_req.out_valid);
                    fail_count++;
                end
                if (o_out_req.out_value !== exp.out_value) begin
                    $error("out_value: expected %0d, got %0d",
                           exp.out_value, o_out_req.out_value);
                    fail_count++;
                end
                if (o_out_req.next_pc !== exp.next_pc) begin
                    $error("next_pc: expected %0d, got %0d", exp.next_pc, o_out_req.next_pc);
                    fail_count++;
                end
                if (o_out_req.acc_now !== exp.acc_now) begin
                    $error("acc_now: expected %0d, got %0d", exp.acc_now, o_out_req.acc_now);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            n = ($urandom_range(0, 9) < 3) ? idle_len(out_quiet) : 0;
            stall_left  <= (n > 0) ? n - 1 : 0;
            i_out_stall <= (n > 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("accumulator_machine_core_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int k = 0; k < MEM_WORDS; k++) shadow_mem[k] = '0;
        shadow_pc   = '0;
        shadow_acc  = '0;
        shadow_halt = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_cases();
        test_instruction_set();
        test_random_programs(600);
        test_random_noise(150);
        test_random_programs(520);

        i_in_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TICKS) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("accumulator_machine_core_test: PASS");
        end else begin
            $display("accumulator_machine_core_test: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
